// ----- rtl/core/rti_pkg.sv -----
// Shared widths, register indexes and helpers for the ray/triangle intersect core.
// Used by rti_div and ray_triangle_intersect. No dependencies.
package rti_pkg;

  localparam int VW      = 32;          // Q16.16 coordinate width
  localparam int EW      = VW + 1;      // vertex difference width
  localparam int XW      = 67;          // cross product component width
  localparam int DW      = EW + XW + 2; // dot product width
  localparam int FRAC    = 16;          // fraction bits
  localparam int QB      = 48;          // quotient magnitude bits
  localparam int QW      = QB + 1;      // signed quotient width
  localparam int SW      = 51;          // wide signed compare/saturate width
  localparam int TOL_W   = 17;
  localparam int IDX_W   = 3;
  localparam int DIV_LAT = QB + 2;

  localparam logic [QB-1:0] QLIM = QB'(1) << (QB - 1);
  localparam logic signed [SW-1:0] Q_ONE = SW'(65536);

  localparam logic [IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] CFG_DIR_X    = 3'd3;
  localparam logic [IDX_W-1:0] CFG_DIR_Y    = 3'd4;
  localparam logic [IDX_W-1:0] CFG_DIR_Z    = 3'd5;
  localparam logic [IDX_W-1:0] CFG_TOL      = 3'd6;

  typedef logic signed [VW-1:0] coord_t;
  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [XW-1:0] cross_t;
  typedef logic signed [DW-1:0] dot_t;
  typedef logic signed [QW-1:0] quo_t;

  typedef struct packed {
    logic miss;
    logic back;
  } det_flags_t;

  function automatic coord_t sat32(input logic signed [SW-1:0] x);
    coord_t r;
    if (x > SW'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (x < SW'(-64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = x[VW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/rti_mul.sv -----
// Two-stage signed multiplier: operand b cut into 32-bit chunks, partial products summed.
// Depends on nothing; instantiated by rti_dot and ray_triangle_intersect.
module rti_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic signed [AW+BW-1:0]  p
);
  localparam int NC  = (BW + 31) / 32;
  localparam int PW  = AW + BW;
  localparam int PPW = AW + 33;

  logic signed [NC*32-1:0] bx;
  logic signed [PPW-1:0]   pp_nxt [NC];
  logic signed [PPW-1:0]   pp_r   [NC];
  logic signed [PW-1:0]    p_nxt;
  logic signed [PW-1:0]    p_r;

  assign bx = (NC*32)'(b);

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      if (k == NC - 1) begin
        pp_nxt[k] = a * $signed({bx[k*32+31], bx[k*32 +: 32]});
      end else begin
        pp_nxt[k] = a * $signed({1'b0, bx[k*32 +: 32]});
      end
    end
  end

  // sum the shifted partial products
  always_comb begin
    p_nxt = '0;
    for (int k = 0; k < NC; k++) begin
      p_nxt = p_nxt + ({{(PW-PPW){pp_r[k][PPW-1]}}, pp_r[k]} <<< (32 * k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/core/rti_dot.sv -----
// Three-term dot product: rti_mul products then a registered sum.
// Depends on rti_mul.
module rti_dot #(
  parameter int AW = 33,
  parameter int BW = 67
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AW-1:0]      a [3],
  input  logic signed [BW-1:0]      b [3],
  output logic signed [AW+BW+1:0]   s
);
  localparam int PW = AW + BW;

  logic signed [PW-1:0]    prod [3];
  logic signed [PW+1:0]    s_nxt;
  logic signed [PW+1:0]    s_r;

  for (genvar i = 0; i < 3; i++) begin : g_mul
    rti_mul #(.AW(AW), .BW(BW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (a[i]),
      .b   (b[i]),
      .p   (prod[i])
    );
  end

  assign s_nxt = (PW+2)'(prod[0]) + (PW+2)'(prod[1]) + (PW+2)'(prod[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s = s_r;

endmodule

// ----- rtl/core/rti_div.sv -----
// Pipelined restoring divider giving (num * 2^16) / den, toward zero, magnitude held to 2^47.
// One quotient bit per stage; depends on rti_pkg.
module rti_div #(
  parameter int W = 102
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [W-1:0]             num,
  input  logic signed [W-1:0]             den,
  output logic signed [rti_pkg::QW-1:0]   quo
);
  import rti_pkg::*;

  logic [W-1:0]  mn;
  logic [W-1:0]  md;
  logic          neg_nxt;
  logic          big_nxt;

  logic [W-1:0]  rem_r  [0:QB];
  logic [W-1:0]  den_r  [0:QB];
  logic [QB-1:0] low_r  [0:QB];
  logic [QB-1:0] qa_r   [0:QB];
  logic          neg_r  [0:QB];
  logic          big_r  [0:QB];

  logic          over;
  logic [QB-1:0] mag;
  quo_t          quo_nxt;
  quo_t          quo_r;

  assign neg_nxt = num[W-1] ^ den[W-1];
  assign mn      = num[W-1] ? W'(-num) : W'(num);
  assign md      = den[W-1] ? W'(-den) : W'(den);
  // quotient of 2^48 or more: clamp without stepping
  assign big_nxt = {{(QB-FRAC){1'b0}}, mn} >= {md, {(QB-FRAC){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= mn >> (QB - FRAC);
      low_r[0] <= {mn[QB-FRAC-1:0], {FRAC{1'b0}}};
      qa_r[0]  <= '0;
      den_r[0] <= md;
      neg_r[0] <= neg_nxt;
      big_r[0] <= big_nxt;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [W:0] rem2;
    logic [W:0] diff;
    logic       ge;

    assign rem2 = {rem_r[k], low_r[k][QB-1]};
    assign diff = rem2 - {1'b0, den_r[k]};
    assign ge   = !diff[W];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[W-1:0] : rem2[W-1:0];
        low_r[k+1] <= low_r[k] << 1;
        qa_r[k+1]  <= {qa_r[k][QB-2:0], ge};
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        big_r[k+1] <= big_r[k];
      end
    end
  end

  assign over    = big_r[QB] || (qa_r[QB] > QLIM);
  assign mag     = over ? QLIM : qa_r[QB];
  assign quo_nxt = neg_r[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

// ----- rtl/core/ray_triangle_intersect.sv -----
// Depth: 60 register stages from in_tdata to out_tdata.
// Throughput: one triangle per cycle; the whole pipeline advances whenever the output
// register is empty or taken, so a stall freezes every stage in place.
// Latency is set mostly by the 50-stage quotient pipeline: one setup stage, one quotient
// bit per stage over 48 stages, one output stage.
// Reset (rst_n low, synchronous): clears all valid bits and loads the ray registers
// with origin 0, direction +z (1.0), tolerance 16.
module ray_triangle_intersect (
  input  logic                          clk,
  input  logic                          rst_n,
  // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
  // vert_c_x, vert_c_y, vert_c_z, 32 bits each
  input  logic [287:0]                  in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // hit, distance, bary_u, bary_v, pos_x, pos_y, pos_z, back_face, 6 zero pad bits
  output logic [199:0]                  out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rti_pkg::IDX_W-1:0]     cfg_index,
  input  logic [31:0]                   cfg_data
);
  import rti_pkg::*;

  localparam int NST = 60;

  // ray registers
  coord_t             org_r [3];
  coord_t             dir_r [3];
  logic [TOL_W-1:0]   tol_r;

  logic               adv;
  logic [NST:1]       vld_r;

  // stage 1: edges and origin offset
  edge_t              e1_r [3];
  edge_t              e2_r [3];
  edge_t              s_r  [3];
  edge_t              dir_e [3];

  // cross product multipliers: 0..5 for p = d x e2, 6..11 for q = s x e1
  edge_t              ma [12];
  edge_t              mb [12];
  logic signed [2*EW-1:0] mp [12];

  // stage 4: cross products, edges delayed to match
  cross_t             p_r [3];
  cross_t             q_r [3];
  edge_t              e1_d [3][3];
  edge_t              e2_d [3][3];
  edge_t              s_d  [3][3];

  // stage 7: dot products
  dot_t               det;
  dot_t               nu;
  dot_t               nv;
  dot_t               nt;
  logic [DW-1:0]      det_abs;
  det_flags_t         dflag;
  det_flags_t         dflag_r [DIV_LAT];

  // stage 57: quotients
  quo_t               u_q;
  quo_t               v_q;
  quo_t               t_q;

  // stage 58: tests and saturation
  logic signed [SW-1:0] tol_s;
  logic signed [SW-1:0] lo_b;
  logic signed [SW-1:0] hi_b;
  logic signed [SW-1:0] u_s;
  logic signed [SW-1:0] v_s;
  logic signed [SW-1:0] t_s;
  logic               miss_nxt;
  logic               miss_r;
  logic               back_r;
  coord_t             t_sat_r;
  coord_t             u_sat_r;
  coord_t             v_sat_r;

  // stage 59: position products
  logic signed [2*VW-1:0] prod_r [3];
  logic               miss2_r;
  logic               back2_r;
  coord_t             t2_r;
  coord_t             u2_r;
  coord_t             v2_r;

  // stage 60: output register
  coord_t             pos_nxt [3];
  coord_t             pos_r   [3];
  logic               hit_r;
  logic               bf_r;
  coord_t             dist_r;
  coord_t             bu_r;
  coord_t             bv_r;

  // advance the whole pipe when the output slot is free or being taken
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // configuration writes; out-of-range indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= 32'sd65536;
      tol_r    <= TOL_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_X: org_r[0] <= cfg_data;
        CFG_ORIGIN_Y: org_r[1] <= cfg_data;
        CFG_ORIGIN_Z: org_r[2] <= cfg_data;
        CFG_DIR_X:    dir_r[0] <= cfg_data;
        CFG_DIR_Y:    dir_r[1] <= cfg_data;
        CFG_DIR_Z:    dir_r[2] <= cfg_data;
        CFG_TOL:      tol_r    <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:1], in_tvalid};
    end
  end

  // stage 1: edge vectors and origin offset, all exact in 33 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= EW'($signed(in_tdata[(3+i)*VW +: VW])) - EW'($signed(in_tdata[i*VW +: VW]));
        e2_r[i] <= EW'($signed(in_tdata[(6+i)*VW +: VW])) - EW'($signed(in_tdata[i*VW +: VW]));
        s_r[i]  <= EW'(org_r[i]) - EW'($signed(in_tdata[i*VW +: VW]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_e[i] = EW'(dir_r[i]);
    end
  end

  // stages 2-3: cross product terms
  for (genvar c = 0; c < 3; c++) begin : g_cross
    localparam int I1 = (c + 1) % 3;
    localparam int I2 = (c + 2) % 3;
    assign ma[2*c]     = dir_e[I1];
    assign mb[2*c]     = e2_r[I2];
    assign ma[2*c+1]   = dir_e[I2];
    assign mb[2*c+1]   = e2_r[I1];
    assign ma[6+2*c]   = s_r[I1];
    assign mb[6+2*c]   = e1_r[I2];
    assign ma[6+2*c+1] = s_r[I2];
    assign mb[6+2*c+1] = e1_r[I1];
  end

  for (genvar m = 0; m < 12; m++) begin : g_xmul
    rti_mul #(.AW(EW), .BW(EW)) u_xmul (
      .clk (clk),
      .en  (adv),
      .a   (ma[m]),
      .b   (mb[m]),
      .p   (mp[m])
    );
  end

  // stage 4: cross differences; delay edges three stages to line up
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p_r[c] <= XW'(mp[2*c]) - XW'(mp[2*c+1]);
        q_r[c] <= XW'(mp[6+2*c]) - XW'(mp[6+2*c+1]);
      end
      e1_d[0] <= e1_r;
      e2_d[0] <= e2_r;
      s_d[0]  <= s_r;
      for (int k = 1; k < 3; k++) begin
        e1_d[k] <= e1_d[k-1];
        e2_d[k] <= e2_d[k-1];
        s_d[k]  <= s_d[k-1];
      end
    end
  end

  // stages 5-7: det = e1.p, u num = s.p, v num = d.q, t num = e2.q
  rti_dot #(.AW(EW), .BW(XW)) u_dot_det (
    .clk (clk), .en (adv), .a (e1_d[2]), .b (p_r), .s (det)
  );
  rti_dot #(.AW(EW), .BW(XW)) u_dot_u (
    .clk (clk), .en (adv), .a (s_d[2]), .b (p_r), .s (nu)
  );
  rti_dot #(.AW(EW), .BW(XW)) u_dot_v (
    .clk (clk), .en (adv), .a (dir_e), .b (q_r), .s (nv)
  );
  rti_dot #(.AW(EW), .BW(XW)) u_dot_t (
    .clk (clk), .en (adv), .a (e2_d[2]), .b (q_r), .s (nt)
  );

  // determinant checks: zero, or magnitude below tolerance * 2^32
  assign det_abs    = det[DW-1] ? DW'(-det) : DW'(det);
  assign dflag.back = det[DW-1];
  assign dflag.miss = (det == '0) || (det_abs < {{(DW-TOL_W-32){1'b0}}, tol_r, 32'b0});

  // hold determinant flags alongside the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      dflag_r[0] <= dflag;
      for (int k = 1; k < DIV_LAT; k++) begin
        dflag_r[k] <= dflag_r[k-1];
      end
    end
  end

  // stages 8-57: three quotient pipelines
  rti_div #(.W(DW)) u_div_u (.clk (clk), .en (adv), .num (nu), .den (det), .quo (u_q));
  rti_div #(.W(DW)) u_div_v (.clk (clk), .en (adv), .num (nv), .den (det), .quo (v_q));
  rti_div #(.W(DW)) u_div_t (.clk (clk), .en (adv), .num (nt), .den (det), .quo (t_q));

  // stage 58: range tests on u, v, u+v and t
  assign tol_s = SW'(tol_r);
  assign lo_b  = -tol_s;
  assign hi_b  = Q_ONE + tol_s;
  assign u_s   = SW'(u_q);
  assign v_s   = SW'(v_q);
  assign t_s   = SW'(t_q);

  assign miss_nxt = dflag_r[DIV_LAT-1].miss
                 || (u_s < lo_b) || (u_s > hi_b)
                 || (v_s < lo_b) || ((u_s + v_s) > hi_b)
                 || (t_s < lo_b);

  always_ff @(posedge clk) begin
    if (adv) begin
      miss_r  <= miss_nxt;
      back_r  <= dflag_r[DIV_LAT-1].back;
      t_sat_r <= sat32(t_s);
      u_sat_r <= sat32(u_s);
      v_sat_r <= sat32(v_s);
    end
  end

  // stage 59: direction times saturated distance
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= dir_r[i] * t_sat_r;
      end
      miss2_r <= miss_r;
      back2_r <= back_r;
      t2_r    <= t_sat_r;
      u2_r    <= u_sat_r;
      v2_r    <= v_sat_r;
    end
  end

  // stage 60: floor shift, add origin, saturate; zero everything on a miss
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = sat32(SW'(org_r[i]) + SW'(prod_r[i] >>> FRAC));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r  <= !miss2_r;
      bf_r   <= miss2_r ? 1'b0 : back2_r;
      dist_r <= miss2_r ? '0 : t2_r;
      bu_r   <= miss2_r ? '0 : u2_r;
      bv_r   <= miss2_r ? '0 : v2_r;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= miss2_r ? '0 : pos_nxt[i];
      end
    end
  end

  assign out_tvalid = vld_r[NST];
  assign out_tdata  = {6'b0, bf_r, pos_r[2], pos_r[1], pos_r[0], bv_r, bu_r, dist_r, hit_r};

endmodule
